// ----- design/gtqi_pkg.sv -----
`default_nettype none

package gtqi_pkg;

  localparam int SIDE_W = 13;
  localparam int TILE_W = 7;
  localparam int NUM_W = 12;
  localparam int QUAD_W = 12;
  localparam int START_W = 12;
  localparam int IDX_W = 24;
  localparam int SPAN_W = TILE_W + 1 + SIDE_W;

  localparam int MIN_GRID_SIDE = 2;
  localparam int MAX_GRID_SIDE = 4096;
  localparam int MAX_TILES_PER_AXIS = 64;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_GRID_COLUMNS = 2'd0,
    REG_GRID_ROWS    = 2'd1,
    REG_TILES        = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

  localparam int LANE_SX = 0;
  localparam int LANE_EX = 1;
  localparam int LANE_SZ = 2;
  localparam int LANE_EZ = 3;
  localparam int NUM_LANES = 4;

  typedef struct packed {
    logic [QUAD_W-1:0] col;
    logic [QUAD_W-1:0] row;
  } quad_t;

  typedef struct packed {
    quad_t quad;
    logic  in_tile;
  } tile_info_t;

  typedef struct packed {
    logic               in_range;
    logic [START_W-1:0] start_x;
    logic [START_W-1:0] start_z;
    logic [SIDE_W-1:0]  count_x;
    logic [SIDE_W-1:0]  count_z;
    logic [IDX_W-1:0]   index_a;
    logic [IDX_W-1:0]   index_b;
    logic [IDX_W-1:0]   index_c;
    logic [IDX_W-1:0]   index_d;
    logic [IDX_W-1:0]   index_e;
    logic [IDX_W-1:0]   index_f;
  } result_t;

endpackage

`default_nettype wire

// ----- design/gtqi_div.sv -----
`default_nettype none

module gtqi_div #(
  parameter int DW = 12,
  parameter int VW = 7,
  parameter int BPS = 4,
  parameter int LANES = 1,
  parameter int SBW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [VW-1:0] divisor,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] dividend [LANES],
  input  logic [SBW-1:0] side_in,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] quotient [LANES],
  output logic [VW-1:0] remainder [LANES],
  output logic [SBW-1:0] side_out
);

  localparam int NS = (DW + BPS - 1) / BPS;
  localparam int PW = NS * BPS;

  logic [NS-1:0]  v;
  logic [NS:0]    rdy;
  logic [PW-1:0]  n  [NS][LANES];
  logic [VW-1:0]  r  [NS][LANES];
  logic [SBW-1:0] sb [NS];

  assign rdy[NS] = out_ready;
  assign in_ready = rdy[0];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic           sv_in;
    logic [PW-1:0]  n_in     [LANES];
    logic [VW-1:0]  r_in     [LANES];
    logic [SBW-1:0] sb_in;
    logic [PW-1:0]  n_next   [LANES];
    logic [VW-1:0]  r_next   [LANES];

    assign rdy[s] = !v[s] || rdy[s+1];

    if (s == 0) begin : g_first
      assign sv_in = in_valid;
      assign sb_in = side_in;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign n_in[l] = PW'(dividend[l]);
        assign r_in[l] = '0;
      end
    end else begin : g_next
      assign sv_in = v[s-1];
      assign sb_in = sb[s-1];
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign n_in[l] = n[s-1][l];
        assign r_in[l] = r[s-1][l];
      end
    end

    always_comb begin : step
      logic [VW:0]   r2;
      logic [VW-1:0] rt;
      logic [PW-1:0] nt;
      for (int l = 0; l < LANES; l++) begin
        rt = r_in[l];
        nt = n_in[l];
        for (int k = 0; k < BPS; k++) begin
          r2 = {rt, nt[PW-1]};
          if (r2 >= {1'b0, divisor}) begin
            r2 = r2 - {1'b0, divisor};
            nt = {nt[PW-2:0], 1'b1};
          end else begin
            nt = {nt[PW-2:0], 1'b0};
          end
          rt = r2[VW-1:0];
        end
        n_next[l] = nt;
        r_next[l] = rt;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (rdy[s]) begin
        v[s] <= sv_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        sb[s] <= sb_in;
        for (int l = 0; l < LANES; l++) begin
          n[s][l] <= n_next[l];
          r[s][l] <= r_next[l];
        end
      end
    end
  end

  assign out_valid = v[NS-1];
  assign side_out  = sb[NS-1];

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quotient[l]  = n[NS-1][l][DW-1:0];
    assign remainder[l] = r[NS-1][l];
  end

endmodule

`default_nettype wire

// ----- design/gtqi_quad.sv -----
`default_nettype none

module gtqi_quad (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [gtqi_pkg::SPAN_W-1:0] span_q [gtqi_pkg::NUM_LANES],
  input  gtqi_pkg::tile_info_t       info,
  output logic                       out_valid,
  input  logic                       out_ready,
  output gtqi_pkg::result_t          result
);

  import gtqi_pkg::*;

  // span stage
  logic               c_valid;
  logic [START_W-1:0] c_sx;
  logic [START_W-1:0] c_sz;
  logic [SIDE_W-1:0]  c_cx;
  logic [SIDE_W-1:0]  c_cz;
  quad_t              c_quad;
  logic               c_in_tile;
  logic               c_quad_ok;

  // product stage
  logic               p_valid;
  logic [START_W-1:0] p_sx;
  logic [START_W-1:0] p_sz;
  logic [SIDE_W-1:0]  p_cx;
  logic [SIDE_W-1:0]  p_cz;
  logic [QUAD_W-1:0]  p_col;
  logic               p_in_tile;
  logic               p_quad_ok;
  logic [IDX_W-1:0]   p_prod;

  logic               o_valid;
  logic               c_ready;
  logic               p_ready;
  logic               o_ready;

  logic [SIDE_W-1:0]  sx_full;
  logic [SIDE_W-1:0]  sz_full;
  logic [SIDE_W-1:0]  cx_next;
  logic [SIDE_W-1:0]  cz_next;
  logic               quad_ok_next;
  logic [IDX_W-1:0]   prod_full;
  logic [IDX_W-1:0]   bl;
  logic [IDX_W-1:0]   tl;
  result_t            result_next;

  assign o_ready  = !o_valid || out_ready;
  assign p_ready  = !p_valid || o_ready;
  assign c_ready  = !c_valid || p_ready;
  assign in_ready = c_ready;

  assign sx_full = span_q[LANE_SX][SIDE_W-1:0];
  assign sz_full = span_q[LANE_SZ][SIDE_W-1:0];
  assign cx_next = span_q[LANE_EX][SIDE_W-1:0] - sx_full + SIDE_W'(1);
  assign cz_next = span_q[LANE_EZ][SIDE_W-1:0] - sz_full + SIDE_W'(1);
  assign quad_ok_next = info.in_tile
                     && (({1'b0, info.quad.col} + SIDE_W'(1)) < cx_next)
                     && (({1'b0, info.quad.row} + SIDE_W'(1)) < cz_next);

  assign prod_full = IDX_W'(c_quad.row) * IDX_W'(c_cx);

  assign bl = p_prod + IDX_W'(p_col);
  assign tl = p_prod + IDX_W'(p_col) + IDX_W'(p_cx);

  always_comb begin
    result_next = '0;
    if (p_in_tile) begin
      result_next.start_x = p_sx;
      result_next.start_z = p_sz;
      result_next.count_x = p_cx;
      result_next.count_z = p_cz;
    end
    if (p_quad_ok) begin
      result_next.in_range = 1'b1;
      result_next.index_a  = bl + IDX_W'(1);
      result_next.index_b  = bl;
      result_next.index_c  = tl;
      result_next.index_d  = bl + IDX_W'(1);
      result_next.index_e  = tl;
      result_next.index_f  = tl + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid <= in_valid;
      end
      if (p_ready) begin
        p_valid <= c_valid;
      end
      if (o_ready) begin
        o_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready) begin
      c_sx      <= sx_full[START_W-1:0];
      c_sz      <= sz_full[START_W-1:0];
      c_cx      <= cx_next;
      c_cz      <= cz_next;
      c_quad    <= info.quad;
      c_in_tile <= info.in_tile;
      c_quad_ok <= quad_ok_next;
    end
    if (p_ready) begin
      p_sx      <= c_sx;
      p_sz      <= c_sz;
      p_cx      <= c_cx;
      p_cz      <= c_cz;
      p_col     <= c_quad.col;
      p_in_tile <= c_in_tile;
      p_quad_ok <= c_quad_ok;
      p_prod    <= prod_full;
    end
    if (o_ready) begin
      result <= result_next;
    end
  end

  assign out_valid = o_valid;

endmodule

`default_nettype wire

// ----- design/grid_tile_quad_index_generator_top.sv -----
`default_nettype none

// Channel  Direction  Handshake           Payload
// config   in         APB write/read      grid_columns, grid_rows, tiles_along_axis
// request  in         in_valid/in_stall   tile_number, quad_column, quad_row
// result   out        out_valid/out_stall in_range, start_x/z, count_x/z, index_a..f
//
// One transfer per cycle on each side unless stalled. Stages: 3 divider stages for
// the tile position, 1 multiply stage, 6 divider stages for the spans, 3 index stages.
// Depth is set by the pipelined restoring dividers, 4 quotient bits per stage.
// rst is synchronous and clears the valid bits and the registers to their defaults.
// A stall holds only the stages that are full; bubbles collapse behind it.

module grid_tile_quad_index_generator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gtqi_pkg::ADDR_W-1:0]   paddr,
  input  logic [gtqi_pkg::DATA_W-1:0]   pwdata,
  output logic [gtqi_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gtqi_pkg::NUM_W-1:0]    tile_number,
  input  logic [gtqi_pkg::QUAD_W-1:0]   quad_column,
  input  logic [gtqi_pkg::QUAD_W-1:0]   quad_row,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          in_range,
  output logic [gtqi_pkg::START_W-1:0]  start_x,
  output logic [gtqi_pkg::START_W-1:0]  start_z,
  output logic [gtqi_pkg::SIDE_W-1:0]   count_x,
  output logic [gtqi_pkg::SIDE_W-1:0]   count_z,
  output logic [gtqi_pkg::IDX_W-1:0]    index_a,
  output logic [gtqi_pkg::IDX_W-1:0]    index_b,
  output logic [gtqi_pkg::IDX_W-1:0]    index_c,
  output logic [gtqi_pkg::IDX_W-1:0]    index_d,
  output logic [gtqi_pkg::IDX_W-1:0]    index_e,
  output logic [gtqi_pkg::IDX_W-1:0]    index_f
);

  import gtqi_pkg::*;

  localparam int DIV_BPS = 4;

  logic [SIDE_W-1:0] grid_columns;
  logic [SIDE_W-1:0] grid_rows;
  logic [TILE_W-1:0] tiles_along_axis;

  logic [SIDE_W-1:0] side_x;
  logic [SIDE_W-1:0] side_z;
  logic [SIDE_W-1:0] side_x_m1;
  logic [SIDE_W-1:0] side_z_m1;
  logic [TILE_W-1:0] tiles;

  reg_idx_t          reg_idx;
  logic              cfg_write;

  // tile position divider
  logic              d1_in_ready;
  logic [NUM_W-1:0]  d1_num  [1];
  logic              d1_valid;
  logic [NUM_W-1:0]  d1_quo  [1];
  logic [TILE_W-1:0] d1_rem  [1];
  quad_t             req_quad;
  quad_t             d1_quad;

  // multiply stage
  logic              m_valid;
  logic              m_ready;
  logic [SPAN_W-1:0] m_num [NUM_LANES];
  tile_info_t        m_info;
  logic              in_tile;
  logic [TILE_W:0]   pos_x;
  logic [TILE_W:0]   pos_z;

  // span divider
  logic              d2_in_ready;
  logic              d2_valid;
  logic [SPAN_W-1:0] d2_quo [NUM_LANES];
  logic [TILE_W-1:0] d2_rem [NUM_LANES];
  tile_info_t        d2_info;

  logic              q_ready;
  logic              q_valid;
  result_t           result;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns     <= SIDE_W'(2);
      grid_rows        <= SIDE_W'(2);
      tiles_along_axis <= TILE_W'(1);
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_GRID_COLUMNS: grid_columns     <= pwdata[SIDE_W-1:0];
        REG_GRID_ROWS:    grid_rows        <= pwdata[SIDE_W-1:0];
        REG_TILES:        tiles_along_axis <= pwdata[TILE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GRID_COLUMNS: prdata = DATA_W'(grid_columns);
      REG_GRID_ROWS:    prdata = DATA_W'(grid_rows);
      REG_TILES:        prdata = DATA_W'(tiles_along_axis);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (grid_columns < SIDE_W'(MIN_GRID_SIDE)) begin
      side_x = SIDE_W'(MIN_GRID_SIDE);
    end else if (32'(grid_columns) > MAX_GRID_SIDE) begin
      side_x = SIDE_W'(MAX_GRID_SIDE);
    end else begin
      side_x = grid_columns;
    end
    if (grid_rows < SIDE_W'(MIN_GRID_SIDE)) begin
      side_z = SIDE_W'(MIN_GRID_SIDE);
    end else if (32'(grid_rows) > MAX_GRID_SIDE) begin
      side_z = SIDE_W'(MAX_GRID_SIDE);
    end else begin
      side_z = grid_rows;
    end
    if (tiles_along_axis == '0) begin
      tiles = TILE_W'(1);
    end else if (32'(tiles_along_axis) > MAX_TILES_PER_AXIS) begin
      tiles = TILE_W'(MAX_TILES_PER_AXIS);
    end else begin
      tiles = tiles_along_axis;
    end
  end

  assign side_x_m1 = side_x - SIDE_W'(1);
  assign side_z_m1 = side_z - SIDE_W'(1);

  assign in_stall     = !d1_in_ready;
  assign d1_num[0]    = tile_number;
  assign req_quad.col = quad_column;
  assign req_quad.row = quad_row;

  gtqi_div #(
    .DW    (NUM_W),
    .VW    (TILE_W),
    .BPS   (DIV_BPS),
    .LANES (1),
    .SBW   ($bits(quad_t))
  ) u_tile_div (
    .clk       (clk),
    .rst       (rst),
    .divisor   (tiles),
    .in_valid  (in_valid),
    .in_ready  (d1_in_ready),
    .dividend  (d1_num),
    .side_in   (req_quad),
    .out_valid (d1_valid),
    .out_ready (m_ready),
    .quotient  (d1_quo),
    .remainder (d1_rem),
    .side_out  (d1_quad)
  );

  assign in_tile = d1_quo[0] < NUM_W'(tiles);
  assign pos_x   = {1'b0, d1_rem[0]};
  assign pos_z   = {1'b0, d1_quo[0][TILE_W-1:0]};
  assign m_ready = !m_valid || d2_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_ready) begin
      m_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready) begin
      m_num[LANE_SX] <= SPAN_W'(pos_x) * SPAN_W'(side_x_m1);
      m_num[LANE_EX] <= SPAN_W'(pos_x + (TILE_W + 1)'(1)) * SPAN_W'(side_x_m1);
      m_num[LANE_SZ] <= SPAN_W'(pos_z) * SPAN_W'(side_z_m1);
      m_num[LANE_EZ] <= SPAN_W'(pos_z + (TILE_W + 1)'(1)) * SPAN_W'(side_z_m1);
      m_info.quad    <= d1_quad;
      m_info.in_tile <= in_tile;
    end
  end

  gtqi_div #(
    .DW    (SPAN_W),
    .VW    (TILE_W),
    .BPS   (DIV_BPS),
    .LANES (NUM_LANES),
    .SBW   ($bits(tile_info_t))
  ) u_span_div (
    .clk       (clk),
    .rst       (rst),
    .divisor   (tiles),
    .in_valid  (m_valid),
    .in_ready  (d2_in_ready),
    .dividend  (m_num),
    .side_in   (m_info),
    .out_valid (d2_valid),
    .out_ready (q_ready),
    .quotient  (d2_quo),
    .remainder (d2_rem),
    .side_out  (d2_info)
  );

  gtqi_quad u_quad (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d2_valid),
    .in_ready  (q_ready),
    .span_q    (d2_quo),
    .info      (d2_info),
    .out_valid (q_valid),
    .out_ready (!out_stall),
    .result    (result)
  );

  assign out_valid = q_valid;
  assign in_range  = result.in_range;
  assign start_x   = result.start_x;
  assign start_z   = result.start_z;
  assign count_x   = result.count_x;
  assign count_z   = result.count_z;
  assign index_a   = result.index_a;
  assign index_b   = result.index_b;
  assign index_c   = result.index_c;
  assign index_d   = result.index_d;
  assign index_e   = result.index_e;
  assign index_f   = result.index_f;

endmodule

`default_nettype wire

// ----- bench/grid_tile_quad_index_generator_top_tb.sv -----
`timescale 1ns / 1ps

module grid_tile_quad_index_generator_top_tb;
  import gtqi_pkg::*;

  class quad_index_checker;
    logic [SIDE_W-1:0] columns_reg;
    logic [SIDE_W-1:0] rows_reg;
    logic [TILE_W-1:0] tiles_reg;
    result_t expected_quads[$];
    int errors;

    function new();
      errors = 0;
      reset_regs();
    endfunction

    function void reset_regs();
      columns_reg = SIDE_W'(2);
      rows_reg = SIDE_W'(2);
      tiles_reg = TILE_W'(1);
    endfunction

    function void write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_GRID_COLUMNS: columns_reg = value[SIDE_W-1:0];
        REG_GRID_ROWS: rows_reg = value[SIDE_W-1:0];
        REG_TILES: tiles_reg = value[TILE_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned clamp_side(logic [SIDE_W-1:0] s);
      if (s < MIN_GRID_SIDE) return MIN_GRID_SIDE;
      if (s > MAX_GRID_SIDE) return MAX_GRID_SIDE;
      return s;
    endfunction

    function longint unsigned tiles_per_axis();
      if (tiles_reg == 0) return 1;
      if (tiles_reg > MAX_TILES_PER_AXIS) return MAX_TILES_PER_AXIS;
      return tiles_reg;
    endfunction

    function result_t predict(logic [NUM_W-1:0] num, logic [QUAD_W-1:0] qcol,
                              logic [QUAD_W-1:0] qrow);
      result_t r;
      longint unsigned cols, rows, t, tx, tz, sx, ex, sz, ez, cx, cz, qx, qz, bl;
      r = '0;
      cols = clamp_side(columns_reg);
      rows = clamp_side(rows_reg);
      t = tiles_per_axis();
      qx = qcol;
      qz = qrow;
      tx = num % t;
      tz = num / t;
      if (tz >= t) return r;
      sx = (tx * (cols - 1)) / t;
      ex = ((tx + 1) * (cols - 1)) / t;
      sz = (tz * (rows - 1)) / t;
      ez = ((tz + 1) * (rows - 1)) / t;
      cx = ex - sx + 1;
      cz = ez - sz + 1;
      r.start_x = START_W'(sx);
      r.start_z = START_W'(sz);
      r.count_x = SIDE_W'(cx);
      r.count_z = SIDE_W'(cz);
      if (qx + 1 >= cx || qz + 1 >= cz) return r;
      bl = qz * cx + qx;
      r.in_range = 1'b1;
      r.index_a = IDX_W'(bl + 1);
      r.index_b = IDX_W'(bl);
      r.index_c = IDX_W'(bl + cx);
      r.index_d = IDX_W'(bl + 1);
      r.index_e = IDX_W'(bl + cx);
      r.index_f = IDX_W'(bl + cx + 1);
      return r;
    endfunction

    function void note_request(logic [NUM_W-1:0] num, logic [QUAD_W-1:0] qcol,
                               logic [QUAD_W-1:0] qrow);
      expected_quads.insert(expected_quads.size(), predict(num, qcol, qrow));
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(result_t act);
      result_t exp_r;
      if (expected_quads.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, expected none, actual %h", $time, act);
        return;
      end
      exp_r = expected_quads.pop_front();
      compare_field("in_range", exp_r.in_range, act.in_range);
      compare_field("start_x", exp_r.start_x, act.start_x);
      compare_field("start_z", exp_r.start_z, act.start_z);
      compare_field("count_x", exp_r.count_x, act.count_x);
      compare_field("count_z", exp_r.count_z, act.count_z);
      compare_field("index_a", exp_r.index_a, act.index_a);
      compare_field("index_b", exp_r.index_b, act.index_b);
      compare_field("index_c", exp_r.index_c, act.index_c);
      compare_field("index_d", exp_r.index_d, act.index_d);
      compare_field("index_e", exp_r.index_e, act.index_e);
      compare_field("index_f", exp_r.index_f, act.index_f);
    endfunction

    function int pending();
      return expected_quads.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [NUM_W-1:0] tile_number = '0;
  logic [QUAD_W-1:0] quad_column = '0;
  logic [QUAD_W-1:0] quad_row = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic in_range;
  logic [START_W-1:0] start_x, start_z;
  logic [SIDE_W-1:0] count_x, count_z;
  logic [IDX_W-1:0] index_a, index_b, index_c, index_d, index_e, index_f;

  quad_index_checker sb = new();
  result_t seen;
  int unsigned stall_tick = 0;
  int burst_left = 0;

  grid_tile_quad_index_generator_top dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .tile_number(tile_number), .quad_column(quad_column), .quad_row(quad_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .in_range(in_range), .start_x(start_x), .start_z(start_z),
    .count_x(count_x), .count_z(count_z),
    .index_a(index_a), .index_b(index_b), .index_c(index_c),
    .index_d(index_d), .index_e(index_e), .index_f(index_f)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen = {in_range, start_x, start_z, count_x, count_z,
              index_a, index_b, index_c, index_d, index_e, index_f};
      sb.check_result(seen);
    end
    stall_tick <= stall_tick + 1;
    case (stall_tick[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 1) == 1);
      2'd2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= ((stall_tick % 5) < 2);
    endcase
  end

  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic configure(int unsigned cols, int unsigned rows, int unsigned tiles);
    write_reg(REG_GRID_COLUMNS, cols);
    write_reg(REG_GRID_ROWS, rows);
    write_reg(REG_TILES, tiles);
  endtask

  task automatic send_request(logic [NUM_W-1:0] num, logic [QUAD_W-1:0] qcol,
                              logic [QUAD_W-1:0] qrow);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    tile_number <= num;
    quad_column <= qcol;
    quad_row <= qrow;
    do @(posedge clk); while (in_stall);
    sb.note_request(num, qcol, qrow);
  endtask

  // drain the pipeline before touching the registers
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic int unsigned pick_side();
    case ($urandom_range(0, 5))
      0: return $urandom_range(2, 16);
      1: return $urandom_range(2, 64);
      2: return $urandom_range(2, 4096);
      3: return $urandom_range(0, 8191);
      4: return 4096;
      default: return $urandom_range(2, 300);
    endcase
  endfunction

  function automatic int unsigned pick_tiles();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 4);
      1: return $urandom_range(0, 127);
      2: return $urandom_range(1, 16);
      default: return 64;
    endcase
  endfunction

  task automatic random_request();
    longint unsigned t;
    int unsigned num, qcol, qrow, kind;
    result_t span;
    kind = $urandom_range(0, 19);
    t = sb.tiles_per_axis();
    if (kind < 2) begin
      num = $urandom_range(0, 4095);
      qcol = $urandom_range(0, 4095);
      qrow = $urandom_range(0, 4095);
    end else begin
      num = $urandom_range(0, int'(t * t) - 1);
      span = sb.predict(NUM_W'(num), '0, '0);
      if (kind < 4 || span.count_x < 2 || span.count_z < 2) begin
        qcol = $urandom_range(0, 4095);
        qrow = (kind == 2) ? $urandom_range(0, 4095) : $urandom_range(0, span.count_z);
      end else begin
        qcol = (kind == 4) ? span.count_x - 2 : $urandom_range(0, span.count_x - 2);
        qrow = (kind == 5) ? span.count_z - 2 : $urandom_range(0, span.count_z - 2);
      end
    end
    send_request(NUM_W'(num), QUAD_W'(qcol), QUAD_W'(qrow));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: one tile of a 2x2 grid
    send_request(0, 0, 0);
    send_request(0, 1, 0);
    send_request(0, 0, 1);
    send_request(1, 0, 0);
    send_request(4095, 4095, 4095);
    settle();
    write_reg(REG_NONE, 32'd5);
    send_request(0, 0, 0);
    settle();

    configure(4096, 4096, 1);
    send_request(0, 4094, 4094);
    send_request(0, 4095, 0);
    send_request(0, 0, 0);
    send_request(0, 4094, 0);
    settle();

    configure(4096, 4096, 64);
    send_request(4095, 63, 63);
    send_request(4095, 64, 0);
    send_request(4032, 0, 0);
    send_request(63, 0, 0);
    settle();

    // clamped sides and tile count
    configure(0, 8191, 0);
    send_request(0, 0, 4094);
    send_request(0, 0, 0);
    send_request(1, 0, 0);
    settle();

    configure(8191, 1, 127);
    send_request(0, 0, 0);
    send_request(4095, 0, 0);
    send_request(4095, 63, 0);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) configure(2, 2, 64);
      else if (phase == 7) configure(4096, 4096, 64);
      else configure(pick_side(), pick_side(), pick_tiles());
      for (int i = 0; i < 144; i++) random_request();
      settle();
    end

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/gtqi_pkg.sv
design/gtqi_div.sv
design/gtqi_quad.sv
design/grid_tile_quad_index_generator_top.sv
bench/grid_tile_quad_index_generator_top_tb.sv
